### hdl/pn2d_pkg.sv
// Shared types, widths and rounding helper for the 2D gradient-noise pipeline.
package pn2d_pkg;

  localparam int GRID_SIZE_DEF       = 128;
  localparam int COORD_FRAC_BITS_DEF = 8;

  // Field widths of the stream payload
  localparam int CRD_W   = 15;
  localparam int IDX_W   = 7;
  localparam int GRAD_W  = 16;
  localparam int NOISE_W = 17;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 24;

  // Fade datapath widths (Q16)
  localparam int FADE_ONE = 65536;
  localparam int FADE_W   = 18;
  localparam int T_W      = 24;
  localparam int P_W      = 41;

  // Dot product result width (Q14)
  localparam int DOT_W = 18;

  typedef logic signed [GRAD_W-1:0] grad_t;

  // One gradient table entry, x component in the low half
  typedef struct packed {
    grad_t gy;
    grad_t gx;
  } gvec_t;

  // Round a Q16-scaled product to its integer part, half up
  function automatic logic signed [T_W-1:0] rnd16(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] s;
    s = (p + P_W'(32768)) >>> 16;
    return s[T_W-1:0];
  endfunction

endpackage

### hdl/pn2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pn2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/pn2d_fade.sv
// Pipelined quintic fade 6w^5-15w^4+10w^3 in Q16, Horner form, one product per stage.
module pn2d_fade import pn2d_pkg::*; #(
  parameter int FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [FRAC_BITS-1:0]     frac_i,
  output logic signed [FADE_W-1:0] fade_o
);

  logic signed [16:0]       w_c;
  logic signed [T_W-1:0]    t1_c, t2_c, t3_c, t4_c, t5_c;
  logic signed [P_W-1:0]    p1_d, p2_d, p3_d, p4_d;
  logic signed [P_W-1:0]    p1_q, p2_q, p3_q, p4_q;
  logic signed [16:0]       w2_q, w3_q, w4_q;
  logic signed [FADE_W-1:0] fade_q;

  // Widen the fraction to Q16 and run one Horner step per stage
  always_comb begin
    w_c  = signed'(17'(frac_i) << (16 - FRAC_BITS));
    t1_c = T_W'(w_c) * T_W'(6) - T_W'(15 * FADE_ONE);
    p1_d = t1_c * w_c;
    t2_c = rnd16(p1_q) + T_W'(10 * FADE_ONE);
    p2_d = t2_c * w2_q;
    t3_c = rnd16(p2_q);
    p3_d = t3_c * w3_q;
    t4_c = rnd16(p3_q);
    p4_d = t4_c * w4_q;
    t5_c = rnd16(p4_q);
  end

  // Advance the stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q   <= p1_d;
      w2_q   <= w_c;
      p2_q   <= p2_d;
      w3_q   <= w2_q;
      p3_q   <= p3_d;
      w4_q   <= w3_q;
      p4_q   <= p4_d;
      fade_q <= FADE_W'(t5_c);
    end
  end

  assign fade_o = fade_q;

endmodule

### hdl/pn2d_addr.sv
// Corner index wrap, table address generation and gradient write path.
module pn2d_addr import pn2d_pkg::*; #(
  parameter int GRID_SIZE       = GRID_SIZE_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  localparam int AW             = $clog2(GRID_SIZE * GRID_SIZE)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic             op_i,
  input  logic [CRD_W-1:0] coord_x_i,
  input  logic [CRD_W-1:0] coord_y_i,
  input  logic [IDX_W-1:0] grad_col_i,
  input  logic [IDX_W-1:0] grad_row_i,
  input  gvec_t            wr_vec_i,
  output logic             wr_en_o,
  output logic [AW-1:0]    wr_addr_o,
  output gvec_t            wr_data_o,
  output logic [AW-1:0]    rd_addr_o [4]
);

  localparam int IW    = $clog2(GRID_SIZE);
  localparam int CW    = CRD_W + 1;
  localparam int K     = 26;
  localparam int RECIP = (2 ** K + GRID_SIZE - 1) / GRID_SIZE;
  localparam int QW    = CW + K;

  logic [CW-1:0] idx_c [4];
  logic [QW-1:0] prod_c [4];
  logic [CW-1:0] idx2_q [4];
  logic [CW-1:0] quo2_q [4];
  logic [IW-1:0] rem3_q [4];
  logic [AW-1:0] rd4_q [4];
  logic          wen2_q, wen3_q, wen4_q;
  logic          inrange_c;
  logic [AW-1:0] wa_c, wa2_q, wa3_q, wa4_q;
  gvec_t         wd2_q, wd3_q, wd4_q;

  // Corner indices x0, x0+1, y0, y0+1 and their quotients by the grid size
  always_comb begin
    idx_c[0] = CW'(coord_x_i >> COORD_FRAC_BITS);
    idx_c[1] = idx_c[0] + CW'(1);
    idx_c[2] = CW'(coord_y_i >> COORD_FRAC_BITS);
    idx_c[3] = idx_c[2] + CW'(1);
    for (int i = 0; i < 4; i++) begin
      prod_c[i] = QW'(idx_c[i]) * QW'(RECIP);
    end
    inrange_c = (32'(grad_col_i) < 32'(GRID_SIZE)) && (32'(grad_row_i) < 32'(GRID_SIZE));
    wa_c      = AW'(32'(grad_col_i) * 32'(GRID_SIZE) + 32'(grad_row_i));
  end

  // Quotient, remainder and address stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        idx2_q[i] <= idx_c[i];
        quo2_q[i] <= prod_c[i][QW-1:K];
        rem3_q[i] <= IW'(idx2_q[i] - CW'(quo2_q[i] * CW'(GRID_SIZE)));
      end
      rd4_q[0] <= AW'(rem3_q[0]) * AW'(GRID_SIZE) + AW'(rem3_q[2]);
      rd4_q[1] <= AW'(rem3_q[1]) * AW'(GRID_SIZE) + AW'(rem3_q[2]);
      rd4_q[2] <= AW'(rem3_q[0]) * AW'(GRID_SIZE) + AW'(rem3_q[3]);
      rd4_q[3] <= AW'(rem3_q[1]) * AW'(GRID_SIZE) + AW'(rem3_q[3]);
      wa2_q <= wa_c;
      wa3_q <= wa2_q;
      wa4_q <= wa3_q;
      wd2_q <= wr_vec_i;
      wd3_q <= wd2_q;
      wd4_q <= wd3_q;
    end
  end

  // Write strobe travels with its transaction; drop writes outside the grid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wen2_q <= 1'b0;
      wen3_q <= 1'b0;
      wen4_q <= 1'b0;
    end else if (en_i) begin
      wen2_q <= valid_i && !op_i && inrange_c;
      wen3_q <= wen2_q;
      wen4_q <= wen3_q;
    end
  end

  assign wr_en_o   = wen4_q;
  assign wr_addr_o = wa4_q;
  assign wr_data_o = wd4_q;
  assign rd_addr_o = rd4_q;

endmodule

### hdl/pn2d_blend.sv
// Corner dot products, bilinear quintic blend and output scaling with saturation.
module pn2d_blend import pn2d_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  gvec_t                      grad_i [4],
  input  logic [COORD_FRAC_BITS-1:0] frac_x_i,
  input  logic [COORD_FRAC_BITS-1:0] frac_y_i,
  input  logic signed [FADE_W-1:0]   fade_x_i,
  input  logic signed [FADE_W-1:0]   fade_y_i,
  output logic signed [NOISE_W-1:0]  noise_o
);

  localparam int F    = COORD_FRAC_BITS;
  localparam int DXW  = F + 2;
  localparam int SW   = DXW + GRAD_W + 1;
  localparam int DFW  = DOT_W + 1;
  localparam int PAW  = DFW + FADE_W;
  localparam int IXW  = DOT_W + 2;
  localparam int PBW  = IXW + 1 + FADE_W;
  localparam int VW   = IXW + 2;

  logic signed [DXW-1:0]     dx0_c, dx1_c, dy0_c, dy1_c;
  logic signed [SW-1:0]      sum_d [4];
  logic signed [SW-1:0]      sum_q [4];
  logic signed [SW-1:0]      rs_c;
  logic signed [DOT_W-1:0]   dot_c [4];
  logic signed [DFW-1:0]     dfa_c, dfb_c;
  logic signed [PAW-1:0]     pa0_d, pa1_d, pa0_q, pa1_q;
  logic signed [DOT_W-1:0]   d0_q, d2_q;
  logic signed [FADE_W-1:0]  fy7_q;
  logic signed [T_W-1:0]     ra0_c, ra1_c, rv_c;
  logic signed [IXW-1:0]     ix0_c, ix1_c, ix0_q;
  logic signed [IXW:0]       dfy_c;
  logic signed [PBW-1:0]     pb_d, pb_q;
  logic signed [VW-1:0]      v_c, h_c;
  logic signed [NOISE_W-1:0] noise_d, noise_q;

  // Offsets from the near and far corners, then the four dot products
  always_comb begin
    dx0_c = signed'(DXW'(frac_x_i));
    dx1_c = dx0_c - DXW'(2 ** F);
    dy0_c = signed'(DXW'(frac_y_i));
    dy1_c = dy0_c - DXW'(2 ** F);
    sum_d[0] = dx0_c * grad_i[0].gx + dy0_c * grad_i[0].gy;
    sum_d[1] = dx1_c * grad_i[1].gx + dy0_c * grad_i[1].gy;
    sum_d[2] = dx0_c * grad_i[2].gx + dy1_c * grad_i[2].gy;
    sum_d[3] = dx1_c * grad_i[3].gx + dy1_c * grad_i[3].gy;
  end

  // Round dots to Q14 and weight the x differences
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rs_c     = (sum_q[i] + SW'(2 ** (F - 1))) >>> F;
      dot_c[i] = rs_c[DOT_W-1:0];
    end
    dfa_c = DFW'(dot_c[1]) - DFW'(dot_c[0]);
    dfb_c = DFW'(dot_c[3]) - DFW'(dot_c[2]);
    pa0_d = dfa_c * fade_x_i;
    pa1_d = dfb_c * fade_x_i;
  end

  // Blend along x, then weight the y difference
  always_comb begin
    ra0_c = rnd16(P_W'(pa0_q));
    ra1_c = rnd16(P_W'(pa1_q));
    ix0_c = IXW'(d0_q) + IXW'(ra0_c);
    ix1_c = IXW'(d2_q) + IXW'(ra1_c);
    dfy_c = (IXW + 1)'(ix1_c) - (IXW + 1)'(ix0_c);
    pb_d  = dfy_c * fy7_q;
  end

  // Blend along y, scale by half, add half and saturate
  always_comb begin
    rv_c = rnd16(P_W'(pb_q));
    v_c  = VW'(ix0_q) + VW'(rv_c);
    h_c  = ((v_c + VW'(1)) >>> 1) + VW'(8192);
    if (h_c > VW'(65535)) begin
      noise_d = NOISE_W'(65535);
    end else if (h_c < -VW'(65536)) begin
      noise_d = -NOISE_W'(65536);
    end else begin
      noise_d = h_c[NOISE_W-1:0];
    end
  end

  // Advance the blend stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q   <= sum_d;
      d0_q    <= dot_c[0];
      d2_q    <= dot_c[2];
      pa0_q   <= pa0_d;
      pa1_q   <= pa1_d;
      fy7_q   <= fade_y_i;
      ix0_q   <= ix0_c;
      pb_q    <= pb_d;
      noise_q <= noise_d;
    end
  end

  assign noise_o = noise_q;

endmodule

### hdl/perlin_noise_2d_top.sv
// Top level of the 2D gradient-noise evaluator: input stage, gradient banks, pipeline control.
// Throughput: one transaction per cycle while the output is not stalled, set by the nine-stage
// pipeline and the four replicated gradient tables, each read once per cycle at one corner.
// A stalled output freezes all stages; writes produce no result.
// Reset clears only valid state; the gradient tables hold undefined data until written.
module perlin_noise_2d_top import pn2d_pkg::*; #(
  parameter int GRID_SIZE       = GRID_SIZE_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // coord_x[14:0], coord_y[29:15], grad_col[36:30], grad_row[43:37],
  // grad_x[59:44], grad_y[75:60], zero pad [79:76]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // op: 0 write gradient entry, 1 evaluate
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // noise_value[16:0], zero pad [23:17]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);
  localparam int F  = COORD_FRAC_BITS;

  logic                     en;
  logic                     vld1_q, op1_q;
  logic [CRD_W-1:0]         cx1_q, cy1_q;
  logic [IDX_W-1:0]         col1_q, row1_q;
  gvec_t                    wv1_q;
  logic [9:2]               evl_q;
  logic [F-1:0]             fx_q [5:2];
  logic [F-1:0]             fy_q [5:2];
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  gvec_t                    wr_data;
  logic [AW-1:0]            rd_addr [4];
  logic [$bits(gvec_t)-1:0] rd_raw [4];
  gvec_t                    grad [4];
  logic signed [FADE_W-1:0] fade_x, fade_y;
  logic signed [NOISE_W-1:0] noise;

  // Whole pipeline moves unless a result is waiting to be taken
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q    <= s_axis_tuser_i;
      cx1_q    <= s_axis_tdata_i[14:0];
      cy1_q    <= s_axis_tdata_i[29:15];
      col1_q   <= s_axis_tdata_i[36:30];
      row1_q   <= s_axis_tdata_i[43:37];
      wv1_q.gx <= s_axis_tdata_i[59:44];
      wv1_q.gy <= s_axis_tdata_i[75:60];
      fx_q[2]  <= cx1_q[F-1:0];
      fy_q[2]  <= cy1_q[F-1:0];
      for (int i = 3; i <= 5; i++) begin
        fx_q[i] <= fx_q[i-1];
        fy_q[i] <= fy_q[i-1];
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      evl_q  <= '0;
    end else if (en) begin
      vld1_q <= s_axis_tvalid_i;
      evl_q  <= {evl_q[8:2], vld1_q && op1_q};
    end
  end

  pn2d_addr #(
    .GRID_SIZE       (GRID_SIZE),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_addr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vld1_q),
    .op_i       (op1_q),
    .coord_x_i  (cx1_q),
    .coord_y_i  (cy1_q),
    .grad_col_i (col1_q),
    .grad_row_i (row1_q),
    .wr_vec_i   (wv1_q),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_addr_o  (rd_addr)
  );

  // One table copy per corner, all written together
  for (genvar g = 0; g < 4; g++) begin : g_bank
    pn2d_ram #(
      .WIDTH ($bits(gvec_t)),
      .DEPTH (GRID_SIZE * GRID_SIZE)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_en && en),
      .waddr_i (wr_addr),
      .wdata_i (wr_data),
      .re_i    (en),
      .raddr_i (rd_addr[g]),
      .rdata_o (rd_raw[g])
    );
    assign grad[g] = gvec_t'(rd_raw[g]);
  end

  pn2d_fade #(.FRAC_BITS(F)) u_fade_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .frac_i (cx1_q[F-1:0]),
    .fade_o (fade_x)
  );

  pn2d_fade #(.FRAC_BITS(F)) u_fade_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .frac_i (cy1_q[F-1:0]),
    .fade_o (fade_y)
  );

  pn2d_blend #(.COORD_FRAC_BITS(F)) u_blend (
    .clk_i    (clk_i),
    .en_i     (en),
    .grad_i   (grad),
    .frac_x_i (fx_q[5]),
    .frac_y_i (fy_q[5]),
    .fade_x_i (fade_x),
    .fade_y_i (fade_y),
    .noise_o  (noise)
  );

  assign m_axis_tvalid_o = evl_q[9];
  assign m_axis_tdata_o  = {{(OUT_DATA_W - NOISE_W){1'b0}}, noise};

endmodule

### verif/perlin_noise_2d_top_tb.sv
// Self-checking testbench for the 2D gradient-noise evaluator stream block.
module perlin_noise_2d_top_tb import pn2d_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID      = GRID_SIZE_DEF;
  localparam int FRAC      = COORD_FRAC_BITS_DEF;
  localparam int CYC_LIMIT = 400000;

  // Item kinds carried on tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  s_axis_tuser_i = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  perlin_noise_2d_top dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: shadow gradient table and its written flags
  logic signed [15:0] shadow_gx [GRID*GRID];
  logic signed [15:0] shadow_gy [GRID*GRID];
  bit                 written   [GRID*GRID];
  logic [NOISE_W-1:0] noise_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int cycles = 0;
  int sent_items = 0;

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint fade_q16(int f);
    longint w, t;
    w = longint'(f) << (16 - FRAC);
    t = 6 * w - 15 * 65536;
    t = round_sh(w * t, 16) + 10 * 65536;
    t = round_sh(t * w, 16);
    t = round_sh(t * w, 16);
    t = round_sh(t * w, 16);
    return t;
  endfunction

  function automatic longint corner_dot(int cx, int cy, longint dx, longint dy);
    int idx;
    idx = (cx % GRID) * GRID + (cy % GRID);
    return round_sh(dx * shadow_gx[idx] + dy * shadow_gy[idx], FRAC);
  endfunction

  function automatic longint blend(longint a0, longint a1, longint fd);
    return a0 + round_sh((a1 - a0) * fd, 16);
  endfunction

  function automatic logic [NOISE_W-1:0] noise_at(int cx, int cy);
    int x0, y0, fx, fy;
    longint sx, sy, ix0, ix1, v;
    x0 = cx >> FRAC;
    y0 = cy >> FRAC;
    fx = cx & ((1 << FRAC) - 1);
    fy = cy & ((1 << FRAC) - 1);
    sx = fade_q16(fx);
    sy = fade_q16(fy);
    ix0 = blend(corner_dot(x0, y0, fx, fy),
                corner_dot(x0 + 1, y0, fx - (1 << FRAC), fy), sx);
    ix1 = blend(corner_dot(x0, y0 + 1, fx, fy - (1 << FRAC)),
                corner_dot(x0 + 1, y0 + 1, fx - (1 << FRAC), fy - (1 << FRAC)), sx);
    v = floor_sh(blend(ix0, ix1, sy) + 1, 1) + 8192;
    if (v > 65535) v = 65535;
    if (v < -65536) v = -65536;
    return v[NOISE_W-1:0];
  endfunction

  // Send one transaction and update the predictor once it is accepted
  task automatic send_item(logic op, int cx, int cy, int col, int row,
                           logic [15:0] gx, logic [15:0] gy);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {4'b0, gy, gx, 7'(row), 7'(col), 15'(cy), 15'(cx)};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent_items++;
    if (op == OP_WRITE) begin
      shadow_gx[col * GRID + row] = gx;
      shadow_gy[col * GRID + row] = gy;
      written[col * GRID + row] = 1'b1;
    end else begin
      noise_q.push_back(noise_at(cx, cy));
    end
  endtask

  task automatic write_grad(int col, int row, logic [15:0] gx, logic [15:0] gy);
    send_item(OP_WRITE, $urandom_range(32767), $urandom_range(32767), col, row, gx, gy);
  endtask

  // Evaluate only where all four corners are loaded
  task automatic eval_point(int cx, int cy);
    int x0, y0;
    x0 = cx >> FRAC;
    y0 = cy >> FRAC;
    if (written[(x0 % GRID) * GRID + y0 % GRID] &&
        written[((x0 + 1) % GRID) * GRID + y0 % GRID] &&
        written[(x0 % GRID) * GRID + (y0 + 1) % GRID] &&
        written[((x0 + 1) % GRID) * GRID + (y0 + 1) % GRID])
      send_item(OP_EVAL, cx, cy, $urandom_range(127), $urandom_range(127),
                16'($urandom), 16'($urandom));
  endtask

  // Drop the input and wait until every expected result has come
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_grad();
    case ($urandom_range(9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  // Directed: full-scale gradients, cell edges, wrap at the grid boundary
  task automatic test_directed();
    foreach (written[i]) written[i] = 1'b0;
    for (int c = 0; c < GRID; c += GRID - 1)
      for (int r = 0; r < GRID; r += GRID - 1)
        write_grad(c, r, 16'sd16384, -16'sd16384);
    write_grad(0, 0, 16'h7FFF, 16'h8000);
    eval_point(32767, 32767);
    eval_point(32512, 32512);
    eval_point(32640, 32767);
    eval_point(32767, 32512);
    write_grad(1, 1, 16'h8000, 16'h7FFF);
    write_grad(0, 1, 16'hFFFF, 16'h0000);
    write_grad(1, 0, 16'h0001, 16'h5555);
    eval_point(0, 0);
    eval_point(255, 255);
    eval_point(128, 128);
    eval_point(1, 254);
    eval_point(255, 0);
    drain();
  endtask

  // Random: load a small patch plus strays, interleaved with evaluations mostly inside it
  task automatic test_random(int n);
    int cx, cy, goal;
    goal = sent_items + n;
    while (sent_items < goal) begin
      if ($urandom_range(99) < 30) begin
        if ($urandom_range(3) == 0)
          write_grad($urandom_range(127), $urandom_range(127), rand_grad(), rand_grad());
        else
          write_grad($urandom_range(127, 124), $urandom_range(3), rand_grad(), rand_grad());
      end else begin
        case ($urandom_range(3))
          0: begin cx = $urandom_range(32767); cy = $urandom_range(32767); end
          default: begin
            cx = ($urandom_range(127, 124) << FRAC) | $urandom_range(255);
            cy = ($urandom_range(2) << FRAC) | $urandom_range(255);
            if ($urandom_range(1)) cx = 32767 - $urandom_range(255);
          end
        endcase
        eval_point(cx, cy);
      end
    end
  endtask

  task automatic test_pause_until_empty();
    test_random(60);
    drain();
    test_random(60);
  endtask

  // Compare each output transaction with the oldest expected value
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (noise_q.size() == 0) begin
        $display("%0t: unexpected noise result %h", $realtime, m_axis_tdata_o[NOISE_W-1:0]);
        errors++;
      end else begin
        if (m_axis_tdata_o !== OUT_DATA_W'(noise_q[0])) begin
          $display("%0t: noise mismatch expected %h actual %h", $realtime,
                   OUT_DATA_W'(noise_q[0]), m_axis_tdata_o);
          errors++;
        end
        void'(noise_q.pop_front());
      end
    end
  end

  // Randomize output backpressure
  always @(posedge clk_i)
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);

  // Timeout guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("** perlin_noise_2d_top: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 23;
    recv_idle_pct = 58;
    test_directed();
    test_random(400);
    test_pause_until_empty();
    send_idle_pct = 58;
    recv_idle_pct = 23;
    test_random(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(400);
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && noise_q.size() == 0)
      $display("** perlin_noise_2d_top: PASSED **");
    else
      $display("** perlin_noise_2d_top: FAILED **");
    $finish;
  end

endmodule

### perlin_noise_2d_top.f
hdl/pn2d_pkg.sv
hdl/pn2d_ram.sv
hdl/pn2d_fade.sv
hdl/pn2d_addr.sv
hdl/pn2d_blend.sv
hdl/perlin_noise_2d_top.sv
verif/perlin_noise_2d_top_tb.sv
